@@ hdl/lpl_pkg.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpl_pkg - shared types and constants for the linked peak limiter
// Frame and result payloads, register indexes and fixed-point constants.
// ---------------------------------------------------------------------------
package lpl_pkg;

  localparam int MAX_CHANNELS = 8;
  localparam int SAMPLE_BITS  = 24;
  localparam int COEFF_BITS   = 16;
  localparam int CH_BITS      = 4;
  localparam int MAG_BITS     = SAMPLE_BITS;
  localparam logic [SAMPLE_BITS-1:0] UNITY = SAMPLE_BITS'(1) << (SAMPLE_BITS - 1);

  typedef enum logic [1:0] {
    REG_ACTIVE_CHANNELS = 2'd0,
    REG_CEILING         = 2'd1,
    REG_ATTACK_COEFF    = 2'd2,
    REG_RELEASE_COEFF   = 2'd3
  } reg_index_t;

  typedef struct packed {
    logic                          end_of_block;
    logic signed [SAMPLE_BITS-1:0] sample_7;
    logic signed [SAMPLE_BITS-1:0] sample_6;
    logic signed [SAMPLE_BITS-1:0] sample_5;
    logic signed [SAMPLE_BITS-1:0] sample_4;
    logic signed [SAMPLE_BITS-1:0] sample_3;
    logic signed [SAMPLE_BITS-1:0] sample_2;
    logic signed [SAMPLE_BITS-1:0] sample_1;
    logic signed [SAMPLE_BITS-1:0] sample_0;
  } frame_in_t;

  typedef struct packed {
    logic [SAMPLE_BITS-1:0]        applied_gain;
    logic                          out_end_of_block;
    logic signed [SAMPLE_BITS-1:0] out_7;
    logic signed [SAMPLE_BITS-1:0] out_6;
    logic signed [SAMPLE_BITS-1:0] out_5;
    logic signed [SAMPLE_BITS-1:0] out_4;
    logic signed [SAMPLE_BITS-1:0] out_3;
    logic signed [SAMPLE_BITS-1:0] out_2;
    logic signed [SAMPLE_BITS-1:0] out_1;
    logic signed [SAMPLE_BITS-1:0] out_0;
  } frame_out_t;

  // classified frame handed from front to back
  typedef struct packed {
    logic [MAX_CHANNELS-1:0]             neg;
    logic [MAX_CHANNELS-1:0][MAG_BITS-1:0] mag;
    logic [MAG_BITS-1:0]                 peak;
    logic                                eob;
  } job_t;

endpackage

@@ hdl/lpl_front.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpl_front - frame intake and peak search
// Takes one frame, splits sign and magnitude, masks unused channels and
// finds the linked peak one channel per cycle.
// ---------------------------------------------------------------------------
module lpl_front import lpl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  frame_in_t        in_data,
  input  logic [CH_BITS-1:0] chans,
  output logic             job_valid,
  input  logic             job_ready,
  output job_t             job
);

  typedef enum logic [1:0] {S_IDLE, S_SCAN, S_DONE} state_t;
  state_t state;
  logic [2:0] idx;
  logic [SAMPLE_BITS-1:0] smp [MAX_CHANNELS];
  logic [MAG_BITS-1:0] mg;

  assign in_ready  = (state == S_IDLE);
  assign job_valid = (state == S_DONE);

  always_comb begin
    smp[0] = in_data.sample_0; smp[1] = in_data.sample_1;
    smp[2] = in_data.sample_2; smp[3] = in_data.sample_3;
    smp[4] = in_data.sample_4; smp[5] = in_data.sample_5;
    smp[6] = in_data.sample_6; smp[7] = in_data.sample_7;
  end

  assign mg = job.mag[idx];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      idx   <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            for (int k = 0; k < MAX_CHANNELS; k++) begin
              // channel count 0 acts as 1, above 8 saturates
              if (k == 0 || (CH_BITS'(k) < chans)) begin
                job.neg[k] <= smp[k][SAMPLE_BITS-1];
                job.mag[k] <= smp[k][SAMPLE_BITS-1] ? MAG_BITS'(-smp[k]) : smp[k];
              end else begin
                job.neg[k] <= 1'b0;
                job.mag[k] <= '0;
              end
            end
            job.eob  <= in_data.end_of_block;
            job.peak <= '0;
            idx      <= '0;
            state    <= S_SCAN;
          end
        end
        S_SCAN: begin
          if (mg > job.peak) job.peak <= mg;
          idx <= idx + 3'd1;
          if (idx == 3'(MAX_CHANNELS - 1)) state <= S_DONE;
        end
        S_DONE: begin
          if (job_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/lpl_queue.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpl_queue - two-entry job queue
// Decouples the peak search from the gain and scaling engine.
// ---------------------------------------------------------------------------
module lpl_queue import lpl_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic wr_valid,
  output logic wr_ready,
  input  job_t wr_data,
  output logic rd_valid,
  input  logic rd_ready,
  output job_t rd_data
);

  job_t mem [2];
  logic wp, rp;
  logic [1:0] cnt;

  assign wr_ready = (cnt != 2'd2);
  assign rd_valid = (cnt != 2'd0);
  assign rd_data  = mem[rp];

  always_ff @(posedge clk) begin
    if (wr_valid && wr_ready) mem[wp] <= wr_data;
    if (rst) begin
      wp <= 1'b0; rp <= 1'b0; cnt <= '0;
    end else begin
      if (wr_valid && wr_ready) wp <= ~wp;
      if (rd_valid && rd_ready) rp <= ~rp;
      cnt <= cnt + 2'(wr_valid && wr_ready) - 2'(rd_valid && rd_ready);
    end
  end

endmodule

@@ hdl/lpl_back.sv @@
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// lpl_back - gain engine
// Serial restoring divide for the target gain, one-pole smoothing and
// per-channel scaling through one shared multiplier.
// ---------------------------------------------------------------------------
module lpl_back import lpl_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  job_valid,
  output logic                  job_ready,
  input  job_t                  job,
  input  logic [SAMPLE_BITS-1:0] ceil_v,
  input  logic [COEFF_BITS-1:0] attack,
  input  logic [COEFF_BITS-1:0] release_c,
  output logic                  out_valid,
  input  logic                  out_ready,
  output frame_out_t            out_data,
  output logic [SAMPLE_BITS-1:0] gain
);

  localparam int QB = 2 * SAMPLE_BITS;
  typedef enum logic [2:0] {S_IDLE, S_DIV, S_SMOOTH, S_MUL, S_OUT} state_t;
  state_t state;
  job_t j;
  logic [QB-1:0] num;
  logic [SAMPLE_BITS-1:0] rem;
  logic [5:0] cnt;
  logic [SAMPLE_BITS-1:0] target;
  logic [SAMPLE_BITS-1:0] res [MAX_CHANNELS];
  logic [2:0] ch;
  logic [SAMPLE_BITS:0] rem_sh;
  logic [SAMPLE_BITS-1:0] diff;
  logic [COEFF_BITS-1:0] coeff;
  logic [SAMPLE_BITS+COEFF_BITS-1:0] step_p;
  logic [SAMPLE_BITS-1:0] step;
  logic [2*SAMPLE_BITS-1:0] prod;
  logic [SAMPLE_BITS+1:0] m;
  logic [SAMPLE_BITS-1:0] mc;

  assign job_ready = (state == S_IDLE);
  assign out_valid = (state == S_OUT);

  assign rem_sh = {rem, num[QB-1]};
  assign coeff  = (target < gain) ? attack : release_c;
  assign diff   = (gain >= target) ? gain - target : target - gain;
  assign step_p = diff * coeff;
  assign step   = step_p[SAMPLE_BITS+COEFF_BITS-1:COEFF_BITS];
  assign prod   = j.mag[ch] * gain;
  assign m      = (SAMPLE_BITS+2)'((prod + QB'(UNITY >> 1)) >> (SAMPLE_BITS - 1));
  always_comb begin
    mc = (m > (SAMPLE_BITS+2)'(ceil_v)) ? ceil_v : m[SAMPLE_BITS-1:0];
  end

  always_comb begin
    out_data.out_0 = res[0]; out_data.out_1 = res[1];
    out_data.out_2 = res[2]; out_data.out_3 = res[3];
    out_data.out_4 = res[4]; out_data.out_5 = res[5];
    out_data.out_6 = res[6]; out_data.out_7 = res[7];
    out_data.out_end_of_block = j.eob;
    out_data.applied_gain     = gain;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      gain  <= UNITY;
      cnt   <= '0;
      ch    <= '0;
    end else begin
      unique case (state)
        S_IDLE: begin
          if (job_valid) begin
            j <= job;
            if (job.peak > ceil_v) begin
              num   <= {ceil_v, {SAMPLE_BITS-1{1'b0}}, 1'b0} >> 1;
              rem   <= '0;
              cnt   <= '0;
              state <= S_DIV;
            end else begin
              target <= UNITY;
              state  <= S_SMOOTH;
            end
          end
        end
        S_DIV: begin
          // one quotient bit per cycle
          if (rem_sh >= {1'b0, j.peak}) begin
            rem <= SAMPLE_BITS'(rem_sh - {1'b0, j.peak});
            num <= {num[QB-2:0], 1'b1};
          end else begin
            rem <= rem_sh[SAMPLE_BITS-1:0];
            num <= {num[QB-2:0], 1'b0};
          end
          cnt <= cnt + 6'd1;
          if (cnt == 6'(QB - 1)) state <= S_SMOOTH;
          target <= (rem_sh >= {1'b0, j.peak}) ? {num[SAMPLE_BITS-2:0], 1'b1}
                                               : {num[SAMPLE_BITS-2:0], 1'b0};
        end
        S_SMOOTH: begin
          gain  <= (gain >= target) ? target + step : target - step;
          ch    <= '0;
          state <= S_MUL;
        end
        S_MUL: begin
          if (j.neg[ch]) res[ch] <= -mc;
          else res[ch] <= (mc > UNITY - SAMPLE_BITS'(1)) ? UNITY - SAMPLE_BITS'(1) : mc;
          ch <= ch + 3'd1;
          if (ch == 3'(MAX_CHANNELS - 1)) state <= S_OUT;
        end
        S_OUT: begin
          if (out_ready) state <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule

@@ hdl/linked_peak_limiter.sv @@
`timescale 1ns / 1ps
// divide: only for frames whose peak exceeds the ceiling
// front: 8-channel serial peak search, a new frame only once the last job is handed on
// back: 48-step serial divider
// reset: ceiling unity, one channel, coefficients zero, gain unity
// ---------------------------------------------------------------------------
// linked_peak_limiter - channel-linked brickwall peak limiter
// Peak search front, job queue, and a divide/smooth/scale back end.
// ---------------------------------------------------------------------------
module linked_peak_limiter import lpl_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             in_valid,
  output logic             in_ready,
  input  frame_in_t        in_data,
  output logic             out_valid,
  input  logic             out_ready,
  output frame_out_t       out_data,
  input  logic             cfg_valid,
  output logic             cfg_ready,
  input  logic [1:0]       cfg_index,
  input  logic [SAMPLE_BITS-1:0] cfg_data
);

  logic [CH_BITS-1:0] active_channels;
  logic [SAMPLE_BITS-1:0] ceiling;
  logic [COEFF_BITS-1:0] attack_coeff, release_coeff;
  logic [SAMPLE_BITS-1:0] ceil_v, gain;
  logic fj_valid, fj_ready, bj_valid, bj_ready;
  job_t fj, bj;

  assign cfg_ready = 1'b1;
  assign ceil_v = (ceiling == '0 || ceiling > UNITY) ? UNITY : ceiling;

  always_ff @(posedge clk) begin
    if (rst) begin
      active_channels <= CH_BITS'(1);
      ceiling         <= UNITY;
      attack_coeff    <= '0;
      release_coeff   <= '0;
    end else if (cfg_valid) begin
      unique case (reg_index_t'(cfg_index))
        REG_ACTIVE_CHANNELS: active_channels <= cfg_data[CH_BITS-1:0];
        REG_CEILING:         ceiling <= cfg_data;
        REG_ATTACK_COEFF:    attack_coeff <= cfg_data[COEFF_BITS-1:0];
        REG_RELEASE_COEFF:   release_coeff <= cfg_data[COEFF_BITS-1:0];
        default: ;
      endcase
    end
  end

  lpl_front u_front (
    .clk, .rst, .in_valid, .in_ready, .in_data, .chans(active_channels),
    .job_valid(fj_valid), .job_ready(fj_ready), .job(fj)
  );

  lpl_queue u_queue (
    .clk, .rst, .wr_valid(fj_valid), .wr_ready(fj_ready), .wr_data(fj),
    .rd_valid(bj_valid), .rd_ready(bj_ready), .rd_data(bj)
  );

  lpl_back u_back (
    .clk, .rst, .job_valid(bj_valid), .job_ready(bj_ready), .job(bj),
    .ceil_v, .attack(attack_coeff), .release_c(release_coeff),
    .out_valid, .out_ready, .out_data, .gain
  );

  a_gain_range: assert property (@(posedge clk) disable iff (rst) gain <= UNITY)
    else $error("gain above unity");
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("result changed while stalled");
  a_gain_stable: assert property (@(posedge clk) disable iff (rst)
    out_valid |=> $stable(gain) || !$past(out_valid))
    else $error("gain moved while result pending");

endmodule
